@@ design/bpa_pkg.sv @@
// Shared types and constants of the bitmap page allocator.
// No dependencies; every other file imports this package.
`default_nettype none

package bpa_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned PAGE_W   = 19;
  localparam int unsigned COUNT_W  = 20;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned TOTAL_W  = 20;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned CHUNK_W  = 8;

  localparam logic [COUNT_W-1:0] FREE_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_ADD   = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_ZERO   = 3'd1,
    ST_NOMEM  = 3'd2,
    ST_RANGE  = 3'd3,
    ST_DOUBLE = 3'd4
  } status_e;

endpackage

`default_nettype wire

@@ design/bpa_cmd_if.sv @@
// Command, response and configuration channels of the page allocator.
// Depends on bpa_pkg for field widths.
`default_nettype none

interface bpa_cmd_if;
  import bpa_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [PAGE_W-1:0]  page;
  logic [COUNT_W-1:0] count;
  modport source (output valid, command, page, count, input ready);
  modport sink (input valid, command, page, count, output ready);
endinterface

interface bpa_rsp_if;
  import bpa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PAGE_W-1:0]   run_start;
  logic [COUNT_W-1:0]  free_page_count;
  modport source (output valid, status, run_start, free_page_count, input ready);
  modport sink (input valid, status, run_start, free_page_count, output ready);
endinterface

interface bpa_cfg_if;
  import bpa_pkg::*;
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ design/bpa_map_mem.sv @@
// Used/free bitmap storage: one word per 64 pages, single port, registered read.
// Depends on bpa_pkg for the word width.
`default_nettype none

module bpa_map_mem #(
  parameter int unsigned WORDS = 8192,
  parameter int unsigned WIW   = 13
) (
  input  wire logic                      clk_i,
  input  wire logic                      re_i,
  input  wire logic                      we_i,
  input  wire logic [WIW-1:0]            addr_i,
  input  wire logic [bpa_pkg::WORD_W-1:0] wdata_i,
  output      logic [bpa_pkg::WORD_W-1:0] rdata_o
);
  import bpa_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/bpa_ctrl.sv @@
// Command sequencer: word-wise read-modify-write passes and next-fit search.
// Depends on bpa_pkg and the channel interfaces; drives bpa_map_mem.
`default_nettype none

module bpa_ctrl #(
  parameter int unsigned WORDS = 8192,
  parameter int unsigned WIW   = 13,
  parameter int unsigned XW    = 21
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  bpa_cmd_if.sink                         cmd_i,
  bpa_rsp_if.source                       rsp_o,
  input  wire logic [XW-1:0]              tot_i,
  output      logic                       mem_re_o,
  output      logic                       mem_we_o,
  output      logic [WIW-1:0]             mem_addr_o,
  output      logic [bpa_pkg::WORD_W-1:0] mem_wdata_o,
  input  wire logic [bpa_pkg::WORD_W-1:0] mem_rdata_i
);
  import bpa_pkg::*;

  localparam int unsigned WB = $clog2(WORD_W);
  localparam int unsigned CB = $clog2(CHUNK_W);
  localparam int unsigned NB = $clog2(WORD_W / CHUNK_W);
  localparam int unsigned SW = XW + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SSTART, S_RD, S_USE, S_SCAN, S_FAIL, S_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_SEARCH, OP_CHECK, OP_CLR, OP_ADD, OP_MARK
  } op_e;

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [WIW-1:0]     w_q, w_d;
  logic [XW-1:0]      lo_q, lo_d, hi_q, hi_d, cnt_q, cnt_d, run_q, run_d;
  logic [NB-1:0]      chunk_q, chunk_d;
  logic [COUNT_W-1:0] hint_q, hint_d, free_q, free_d;
  logic               retry_q, retry_d;
  status_e            status_q, status_d;
  logic [PAGE_W-1:0]  base_q, base_d;

  logic [XW-1:0]      wbase, hiend, pend, cnt_in, page_in;
  logic [WIW-1:0]     lo_word, last_w;
  logic [WB-1:0]      lo_off, hi_off;
  logic [WORD_W-1:0]  mask, rd;
  logic               is_last;
  logic [WB:0]        pc;
  logic [SW-1:0]      sum_cnt, sum_pc;
  logic [COUNT_W-1:0] free_cnt_sat, free_pc_sat, free_sub;

  // chunk scan results
  logic [XW-1:0]      run_v, base_v;
  logic               found_v;

  assign rd      = mem_rdata_i;
  assign wbase   = XW'({w_q, {WB{1'b0}}});
  assign hiend   = hi_q - XW'(1);
  assign lo_word = lo_q[WB +: WIW];
  assign last_w  = hiend[WB +: WIW];
  assign is_last = (w_q == last_w);
  assign lo_off  = (w_q == lo_word) ? lo_q[WB-1:0] : '0;
  assign hi_off  = is_last ? hiend[WB-1:0] : '1;
  assign mask    = ({WORD_W{1'b1}} << lo_off) & ({WORD_W{1'b1}} >> (WB'(WORD_W - 1) - hi_off));
  assign pc      = (WB + 1)'($countones(rd & mask));

  assign cnt_in  = XW'(cmd_i.count);
  assign page_in = XW'(cmd_i.page);
  assign pend    = page_in + cnt_in;

  assign sum_cnt      = SW'(free_q) + SW'(cnt_q);
  assign sum_pc       = SW'(free_q) + SW'(pc);
  assign free_cnt_sat = (sum_cnt > SW'(FREE_MAX)) ? FREE_MAX : sum_cnt[COUNT_W-1:0];
  assign free_pc_sat  = (sum_pc > SW'(FREE_MAX)) ? FREE_MAX : sum_pc[COUNT_W-1:0];
  assign free_sub     = (XW'(free_q) >= cnt_q) ? COUNT_W'(XW'(free_q) - cnt_q) : '0;

  always_comb begin
    logic [WB-1:0] idx;
    logic [XW-1:0] pos;
    run_v   = run_q;
    found_v = 1'b0;
    base_v  = '0;
    for (int k = 0; k < CHUNK_W; k++) begin
      idx = {chunk_q, CB'(k)};
      pos = wbase + XW'(idx);
      if (mask[idx] && !found_v) begin
        run_v = rd[idx] ? '0 : run_v + XW'(1);
        if (run_v == cnt_q) begin
          found_v = 1'b1;
          base_v  = pos + XW'(1) - cnt_q;
        end
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    w_d      = w_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    cnt_d    = cnt_q;
    run_d    = run_q;
    chunk_d  = chunk_q;
    hint_d   = hint_q;
    free_d   = free_q;
    retry_d  = retry_q;
    status_d = status_q;
    base_d   = base_q;

    mem_re_o    = 1'b0;
    mem_we_o    = 1'b0;
    mem_wdata_o = rd & ~mask;

    case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = '1;
        w_d         = w_q + WIW'(1);
        if (w_q == WIW'(WORDS - 1)) begin
          w_d     = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_i.valid) begin
          base_d   = '0;
          status_d = ST_OK;
          cnt_d    = cnt_in;
          case (cmd_e'(cmd_i.command))
            CMD_ALLOC: begin
              if (cnt_in == '0) begin
                status_d = ST_ZERO;
                state_d  = S_OUT;
              end else begin
                op_d    = OP_SEARCH;
                lo_d    = XW'(hint_q);
                hi_d    = tot_i;
                retry_d = (hint_q != '0);
                state_d = S_SSTART;
              end
            end
            CMD_FREE, CMD_ADD: begin
              if (pend > tot_i) begin
                status_d = ST_RANGE;
                state_d  = S_OUT;
              end else if (cnt_in == '0) begin
                state_d = S_OUT;
              end else begin
                op_d    = (cmd_e'(cmd_i.command) == CMD_FREE) ? OP_CHECK : OP_ADD;
                lo_d    = page_in;
                hi_d    = pend;
                w_d     = page_in[WB +: WIW];
                state_d = S_RD;
              end
            end
            default: begin
              status_d = ST_RANGE;
              state_d  = S_OUT;
            end
          endcase
        end
      end
      S_SSTART: begin
        run_d = '0;
        if (lo_q >= hi_q) begin
          state_d = S_FAIL;
        end else begin
          w_d     = lo_word;
          state_d = S_RD;
        end
      end
      S_RD: begin
        mem_re_o = 1'b1;
        state_d  = S_USE;
      end
      S_USE: begin
        state_d = S_RD;
        w_d     = w_q + WIW'(1);
        case (op_q)
          OP_SEARCH: begin
            // skip a word with no free page in scope
            if (&(rd | ~mask)) begin
              run_d = '0;
              if (is_last) begin
                state_d = S_FAIL;
              end
            end else begin
              w_d     = w_q;
              chunk_d = '0;
              state_d = S_SCAN;
            end
          end
          OP_CHECK: begin
            if (|(~rd & mask)) begin
              status_d = ST_DOUBLE;
              state_d  = S_OUT;
            end else if (is_last) begin
              op_d = OP_CLR;
              w_d  = lo_word;
            end
          end
          OP_CLR: begin
            mem_we_o = 1'b1;
            if (is_last) begin
              free_d  = free_cnt_sat;
              state_d = S_OUT;
            end
          end
          OP_ADD: begin
            mem_we_o = 1'b1;
            free_d   = free_pc_sat;
            if (is_last) begin
              state_d = S_OUT;
            end
          end
          OP_MARK: begin
            mem_we_o    = 1'b1;
            mem_wdata_o = rd | mask;
            if (is_last) begin
              free_d  = free_sub;
              hint_d  = hi_q[COUNT_W-1:0];
              base_d  = lo_q[PAGE_W-1:0];
              state_d = S_OUT;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        run_d = run_v;
        if (found_v) begin
          op_d    = OP_MARK;
          lo_d    = base_v;
          hi_d    = base_v + cnt_q;
          w_d     = base_v[WB +: WIW];
          state_d = S_RD;
        end else if (chunk_q == '1) begin
          if (is_last) begin
            state_d = S_FAIL;
          end else begin
            w_d     = w_q + WIW'(1);
            state_d = S_RD;
          end
        end else begin
          chunk_d = chunk_q + NB'(1);
        end
      end
      S_FAIL: begin
        hint_d = '0;
        if (retry_q) begin
          retry_d = 1'b0;
          lo_d    = '0;
          state_d = S_SSTART;
        end else begin
          status_d = ST_NOMEM;
          base_d   = '0;
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      op_q     <= OP_SEARCH;
      w_q      <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      cnt_q    <= '0;
      run_q    <= '0;
      chunk_q  <= '0;
      hint_q   <= '0;
      free_q   <= '0;
      retry_q  <= 1'b0;
      status_q <= ST_OK;
      base_q   <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      w_q      <= w_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      cnt_q    <= cnt_d;
      run_q    <= run_d;
      chunk_q  <= chunk_d;
      hint_q   <= hint_d;
      free_q   <= free_d;
      retry_q  <= retry_d;
      status_q <= status_d;
      base_q   <= base_d;
    end
  end

  assign mem_addr_o            = w_q;
  assign cmd_i.ready           = (state_q == S_IDLE);
  assign rsp_o.valid           = (state_q == S_OUT);
  assign rsp_o.status          = status_q;
  assign rsp_o.run_start       = base_q;
  assign rsp_o.free_page_count = free_q;

endmodule

`default_nettype wire

@@ design/bitmap_page_allocator.sv @@
// Top level of the bitmap page allocator: config register, sequencer, bitmap RAM.
// Depends on bpa_pkg, the channel interfaces, bpa_ctrl and bpa_map_mem.
//
//   channel  dir  beat carries                          accepted when
//   cmd_i    in   command, page, count                  valid && ready
//   rsp_o    out  status, run_start, free_page_count    valid && ready
//   cfg_i    in   total_pages                           valid && ready
//
// After reset the bitmap RAM is set to all-used, one 64-page word a cycle,
// and cmd_i.ready stays low until the last word is written.
// One command at a time, bound by the single RAM port: add-region and marking
// read and write back each word in turn; free makes a check pass and then a
// clear pass; a search reads each word, skips one with no free page in scope
// and scans any other word by chunk (8 pages a cycle through the run counter).
// The result is held on rsp_o until taken; cmd_i.ready returns after that.
`default_nettype none

module bitmap_page_allocator #(
  parameter int unsigned MAX_PAGES = 524288
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bpa_cmd_if.sink   cmd_i,
  bpa_rsp_if.source rsp_o,
  bpa_cfg_if.sink   cfg_i
);
  import bpa_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_PAGES);
  localparam int unsigned XW    = (AW + 1 > 21) ? AW + 1 : 21;
  localparam int unsigned WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int unsigned WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [TOTAL_W-1:0] total_q;
  logic [XW-1:0]      tot;
  logic               mem_re, mem_we;
  logic [WIW-1:0]     mem_addr;
  logic [WORD_W-1:0]  mem_wdata, mem_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_W'(524288);
    end else if (cfg_i.valid) begin
      total_q <= cfg_i.data;
    end
  end

  // clamp to the managed range
  assign tot = (XW'(total_q) > XW'(MAX_PAGES)) ? XW'(MAX_PAGES) : XW'(total_q);

  bpa_ctrl #(
    .WORDS (WORDS),
    .WIW   (WIW),
    .XW    (XW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .rsp_o       (rsp_o),
    .tot_i       (tot),
    .mem_re_o    (mem_re),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  bpa_map_mem #(
    .WORDS (WORDS),
    .WIW   (WIW)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

@@ design/bpa_checker.sv @@
// Port-level checks of the page allocator, bound to the top level.
// Depends on bpa_pkg for status codes.
`default_nettype none

module bpa_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          cmd_valid_i,
  input wire logic                          cmd_ready_i,
  input wire logic                          rsp_valid_i,
  input wire logic                          rsp_ready_i,
  input wire logic [bpa_pkg::STATUS_W-1:0]  status_i,
  input wire logic [bpa_pkg::PAGE_W-1:0]    run_start_i,
  input wire logic [bpa_pkg::COUNT_W-1:0]   free_i
);
  import bpa_pkg::*;

  // hold a pending response beat
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i)
      && $stable(free_i))
    else $error("response dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_ready_i && rsp_valid_i))
    else $error("command taken while a response is pending");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (status_i <= ST_DOUBLE))
    else $error("undefined status code");

  a_base_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != ST_OK) |-> (run_start_i == '0))
    else $error("run start set on a failed command");

  a_accept_to_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("ready stayed high after an accepted command");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .run_start_i (rsp_o.run_start),
  .free_i      (rsp_o.free_page_count)
);

`default_nettype wire
